[rtl/bsr_pkg.sv]
// ----------------------------------------------------------------------------
// bsr_pkg
// shared widths, op codes, status codes and the cell control bundle for
// the byte stack with rotate
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int OP_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int N_W      = 7;
  localparam int CAP_W    = 7;
  localparam int STATUS_W = 2;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DUP   = 3'd3,
    OP_SINK  = 3'd4,
    OP_RAISE = 3'd5,
    OP_PRINT = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_DEEP  = 2'd3
  } status_t;

  // what every cell does in a given cycle
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_DUP,
    CMD_POP,
    CMD_SINK,
    CMD_RAISE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      in_window;  // cell depth below the rotation depth
    logic      at_edge;    // cell is the deepest one of the rotation
  } cell_ctl_t;

endpackage

[rtl/bsr_cell.sv]
// ----------------------------------------------------------------------------
// bsr_cell
// one stack position; takes its byte from the neighbour above, the
// neighbour below or the top of the stack, or keeps it
// ----------------------------------------------------------------------------
module bsr_cell (
  input  logic                      clk,
  input  bsr_pkg::cell_ctl_t        ctl,
  input  logic [bsr_pkg::BYTE_W-1:0] prev_byte,
  input  logic [bsr_pkg::BYTE_W-1:0] next_byte,
  input  logic [bsr_pkg::BYTE_W-1:0] top_byte,
  output logic [bsr_pkg::BYTE_W-1:0] cell_byte
);
  import bsr_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    case (ctl.kind)
      CMD_PUSH, CMD_DUP: byte_nxt = prev_byte;
      CMD_POP:           byte_nxt = next_byte;
      CMD_SINK: begin
        if (ctl.at_edge) begin
          byte_nxt = top_byte;
        end else if (ctl.in_window) begin
          byte_nxt = next_byte;
        end
      end
      CMD_RAISE: begin
        if (ctl.in_window) begin
          byte_nxt = prev_byte;
        end
      end
      default: byte_nxt = byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign cell_byte = byte_r;

endmodule

[rtl/byte_stack_with_rotate.sv]
// ----------------------------------------------------------------------------
// byte_stack_with_rotate
// byte lifo built as a chain of shift cells, cell 0 holding the top entry;
// push, pop, peek, duplicate, sink, raise and a top-to-bottom print
// ----------------------------------------------------------------------------
// output: every result lands in the output register in the cycle after its item is taken
// throughput: one item per cycle for all ops but print, output stalls allowing;
// print of f entries streams f results, one per cycle while the output does not stall,
// by rotating the f filled entries through cell 0; no item is taken until it ends
// reset: fill count cleared, capacity back to 64, output empty; the cell bytes
// are not reset, only entries below the fill count are ever read
module byte_stack_with_rotate #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write, capacity register
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bsr_pkg::CAP_W-1:0]    cfg_data,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bsr_pkg::OP_W-1:0]     in_op,
  input  logic [bsr_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [bsr_pkg::N_W-1:0]      in_rotate_depth,
  // result items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsr_pkg::STATUS_W-1:0] out_status,
  output logic                         out_has_byte,
  output logic [bsr_pkg::BYTE_W-1:0]   out_byte_out,
  output logic                         out_last_item
);
  import bsr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);  // fill count width
  localparam int IW = $clog2(DEPTH);      // cell index width

  typedef enum logic {
    ST_IDLE,
    ST_PRINT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     left_r, left_nxt;      // print results still to give
  logic [CAP_W-1:0]  capacity_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_has_byte_r, out_has_byte_nxt;
  logic [BYTE_W-1:0]   out_byte_out_r, out_byte_out_nxt;
  logic                out_last_item_r, out_last_item_nxt;

  // command broadcast to the chain this cycle
  cmd_kind_t         cmd_kind;
  logic [N_W-1:0]    cmd_n;

  logic [BYTE_W-1:0] cell_byte [DEPTH];
  logic [BYTE_W-1:0] top_prev;              // what cell 0 takes on a shift down
  cell_ctl_t         cell_ctl  [DEPTH];

  logic [N_W-1:0]    fill_w;
  logic [CAP_W-1:0]  limit_w;
  logic              full_w;
  logic              empty_w;
  logic              slot_free;
  logic              in_take;
  logic [IW-1:0]     raise_idx;

  // ---------------------------------------------------------------------------
  // status of the stack
  // ---------------------------------------------------------------------------
  assign fill_w    = N_W'(fill_r);
  // capacity saturates at the number of cells built
  assign limit_w   = (capacity_r > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : capacity_r;
  assign full_w    = CAP_W'(fill_r) >= limit_w;
  assign empty_w   = (fill_r == '0);

  // output register can take a new result when empty or being emptied
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = slot_free && (state_r == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // item decode and print sequencing
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt         = state_r;
    fill_nxt          = fill_r;
    left_nxt          = left_r;
    cmd_kind          = CMD_HOLD;
    cmd_n             = '0;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_status_nxt    = out_status_r;
    out_has_byte_nxt  = out_has_byte_r;
    out_byte_out_nxt  = out_byte_out_r;
    out_last_item_nxt = out_last_item_r;

    if (in_take) begin
      out_valid_nxt     = 1'b1;
      out_status_nxt    = STS_OK;
      out_has_byte_nxt  = 1'b0;
      out_byte_out_nxt  = '0;
      out_last_item_nxt = 1'b1;
      case (op_t'(in_op))
        OP_PUSH: begin
          if (full_w) begin
            out_status_nxt = STS_FULL;
          end else begin
            fill_nxt = fill_r + CW'(1);
            cmd_kind = CMD_PUSH;
          end
        end
        OP_POP: begin
          if (empty_w) begin
            out_status_nxt = STS_EMPTY;
          end else begin
            out_has_byte_nxt = 1'b1;
            out_byte_out_nxt = cell_byte[0];
            fill_nxt         = fill_r - CW'(1);
            cmd_kind         = CMD_POP;
          end
        end
        OP_PEEK: begin
          if (empty_w) begin
            out_status_nxt = STS_EMPTY;
          end else begin
            out_has_byte_nxt = 1'b1;
            out_byte_out_nxt = cell_byte[0];
          end
        end
        OP_DUP: begin
          if (empty_w) begin
            out_status_nxt = STS_EMPTY;
          end else if (full_w) begin
            out_status_nxt = STS_FULL;
          end else begin
            fill_nxt = fill_r + CW'(1);
            cmd_kind = CMD_DUP;
          end
        end
        OP_SINK, OP_RAISE: begin
          if (in_rotate_depth > fill_w) begin
            out_status_nxt = STS_DEEP;
          end else if (in_rotate_depth >= N_W'(2)) begin
            // shallow rotations leave the chain alone
            cmd_kind = (op_t'(in_op) == OP_SINK) ? CMD_SINK : CMD_RAISE;
            cmd_n    = in_rotate_depth;
          end
        end
        OP_PRINT: begin
          if (!empty_w) begin
            // top goes out now, the chain turns one step so the next is on top
            out_has_byte_nxt  = 1'b1;
            out_byte_out_nxt  = cell_byte[0];
            out_last_item_nxt = (fill_r == CW'(1));
            cmd_kind          = CMD_SINK;
            cmd_n             = fill_w;
            if (fill_r != CW'(1)) begin
              state_nxt = ST_PRINT;
              left_nxt  = fill_r - CW'(1);
            end
          end
        end
        default: begin
          // unused op code: plain ok result
        end
      endcase
    end else if ((state_r == ST_PRINT) && slot_free) begin
      // one entry per cycle while the output register is free; after fill steps the chain is back in order
      out_valid_nxt     = 1'b1;
      out_status_nxt    = STS_OK;
      out_has_byte_nxt  = 1'b1;
      out_byte_out_nxt  = cell_byte[0];
      out_last_item_nxt = (left_r == CW'(1));
      cmd_kind          = CMD_SINK;
      cmd_n             = fill_w;
      left_nxt          = left_r - CW'(1);
      if (left_r == CW'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // feed into cell 0 from above the stack
  // ---------------------------------------------------------------------------
  assign raise_idx = IW'(cmd_n - N_W'(1));

  always_comb begin
    case (cmd_kind)
      CMD_PUSH:  top_prev = in_data_byte;
      CMD_RAISE: top_prev = cell_byte[raise_idx];  // deepest entry of the rotation
      default:   top_prev = cell_byte[0];          // duplicate keeps the top
    endcase
  end

  // ---------------------------------------------------------------------------
  // chain of cells, cell 0 is the top of the stack
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [BYTE_W-1:0] prev_b;
    logic [BYTE_W-1:0] next_b;

    assign cell_ctl[g].kind      = cmd_kind;
    assign cell_ctl[g].in_window = N_W'(g) < cmd_n;
    assign cell_ctl[g].at_edge   = (N_W'(g) + N_W'(1)) == cmd_n;

    if (g == 0) begin : g_top
      assign prev_b = top_prev;
    end else begin : g_mid
      assign prev_b = cell_byte[g-1];
    end

    if (g == DEPTH - 1) begin : g_bot
      assign next_b = '0;
    end else begin : g_up
      assign next_b = cell_byte[g+1];
    end

    bsr_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[g]),
      .prev_byte (prev_b),
      .next_byte (next_b),
      .top_byte  (cell_byte[0]),
      .cell_byte (cell_byte[g])
    );
  end

  // ---------------------------------------------------------------------------
  // state, counters, configuration and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      left_r      <= '0;
      capacity_r  <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
    out_status_r    <= out_status_nxt;
    out_has_byte_r  <= out_has_byte_nxt;
    out_byte_out_r  <= out_byte_out_nxt;
    out_last_item_r <= out_last_item_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_has_byte  = out_has_byte_r;
  assign out_byte_out  = out_byte_out_r;
  assign out_last_item = out_last_item_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // the fill count never runs past the cells built
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    N_W'(fill_r) <= N_W'(DEPTH))
    else $error("fill count beyond stack depth");

  // a print in progress blocks new items
  a_print_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRINT) |-> !in_ready)
    else $error("item taken during print");

  // print streams without changing the fill count
  a_print_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRINT) |=> $stable(fill_r))
    else $error("fill count moved during print");

  // the last print result always ends the print
  a_print_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_PRINT) && slot_free && (left_r == CW'(1)))
      |=> (state_r == ST_IDLE) && out_valid && out_last_item)
    else $error("print did not end on its last result");

endmodule
